[rtl/earm_pkg.sv]
// ---------------------------------------------------------------------------
// earm_pkg
// Shared types and fixed constants of the Euler z-x-z rotation matrix unit.
// ---------------------------------------------------------------------------
package earm_pkg;

    localparam int unsigned Q_BITS     = 31;
    localparam int unsigned OUT_BITS   = 16;
    localparam int unsigned POLY_TERMS = 8;

    localparam logic [Q_BITS-1:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [Q_BITS-1:0] HALF_PI_Q30 = 31'd1686629713;

    // Pipeline depths: sine of a quarter angle, sine/cosine pair, matrix.
    localparam int unsigned SQ_LAT = 3 + 3 * POLY_TERMS + 2;
    localparam int unsigned SC_LAT = SQ_LAT + 2;
    localparam int unsigned MX_LAT = 5;

    typedef struct packed {
        logic              s_neg;
        logic [Q_BITS-1:0] s_mag;
        logic              c_neg;
        logic [Q_BITS-1:0] c_mag;
    } t_sincos;

    typedef logic [8:0][OUT_BITS-1:0] t_matrix;

endpackage

[rtl/euler_angle_rotation_matrix_unit.sv]
// ---------------------------------------------------------------------------
// euler_angle_rotation_matrix_unit
// Three binary Euler angles in, the nine z-x-z rotation matrix entries out.
// ---------------------------------------------------------------------------
// The unit takes one angle triple in every clock cycle and busy stays low.
// Each item's nine entries appear on the o_m ports with o_valid high for
// one cycle, once the item has passed the sine/cosine and matrix stages.
// The receiver cannot stall the unit, so results must be taken as they come.
// The pipeline depth is set by the quarter-turn sine pipelines: 29 stages, of
// which 24 are the eight nested series terms (a multiply, a reciprocal
// multiply and a correction each); quadrant folding adds two stages and
// the product, sum and rounding pipeline adds five.
// ---------------------------------------------------------------------------
module euler_angle_rotation_matrix_unit #(
    parameter int unsigned ANGLE_BITS = 16,
    parameter int unsigned FRAC_BITS  = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ANGLE_BITS-1:0]  i_alpha_angle,
    input  logic [ANGLE_BITS-1:0]  i_beta_angle,
    input  logic [ANGLE_BITS-1:0]  i_gamma_angle,
    output logic                   o_valid,
    output logic signed [15:0]     o_m00,
    output logic signed [15:0]     o_m01,
    output logic signed [15:0]     o_m02,
    output logic signed [15:0]     o_m10,
    output logic signed [15:0]     o_m11,
    output logic signed [15:0]     o_m12,
    output logic signed [15:0]     o_m20,
    output logic signed [15:0]     o_m21,
    output logic signed [15:0]     o_m22
);
    import earm_pkg::*;

    localparam int unsigned LAT     = SC_LAT + MX_LAT;
    localparam int          OUT_LIM = 1 << FRAC_BITS;

    logic    w_accept;
    t_sincos w_sc_a;
    t_sincos w_sc_b;
    t_sincos w_sc_c;
    t_matrix w_m;

    logic [SC_LAT-1:0] r_vld;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SC_LAT-2:0], w_accept};
        end
    end

    earm_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sc_alpha (
        .i_clk   (i_clk),
        .i_angle (i_alpha_angle),
        .o_sc    (w_sc_a)
    );

    earm_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sc_beta (
        .i_clk   (i_clk),
        .i_angle (i_beta_angle),
        .o_sc    (w_sc_b)
    );

    earm_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sc_gamma (
        .i_clk   (i_clk),
        .i_angle (i_gamma_angle),
        .o_sc    (w_sc_c)
    );

    earm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[SC_LAT-1]),
        .i_a     (w_sc_a),
        .i_b     (w_sc_b),
        .i_c     (w_sc_c),
        .o_valid (o_valid),
        .o_m     (w_m)
    );

    assign o_m00 = $signed(w_m[0]);
    assign o_m01 = $signed(w_m[1]);
    assign o_m02 = $signed(w_m[2]);
    assign o_m10 = $signed(w_m[3]);
    assign o_m11 = $signed(w_m[4]);
    assign o_m12 = $signed(w_m[5]);
    assign o_m20 = $signed(w_m[6]);
    assign o_m21 = $signed(w_m[7]);
    assign o_m22 = $signed(w_m[8]);

    // Every accepted item leaves after exactly the pipeline latency.
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("accepted item did not leave after the pipeline latency");

    // No result leaves without an item accepted the latency before.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LAT))
        else $error("result left with no matching accepted item");

    // The m00 and m22 entries stay within plus or minus one when the format holds it.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (FRAC_BITS > 14)
            || ((o_m22 <= OUT_LIM) && (o_m22 >= -OUT_LIM)
                && (o_m00 <= OUT_LIM) && (o_m00 >= -OUT_LIM)))
        else $error("matrix entry beyond the clamp limit");

endmodule

[rtl/earm_poly_term.sv]
// ---------------------------------------------------------------------------
// earm_poly_term
// One nested term of the sine series: t' = 1 - floor(floor(x2*t) / DIV),
// in three stages with the division done by a reciprocal and a correction.
// ---------------------------------------------------------------------------
module earm_poly_term #(
    parameter int unsigned DIV = 6
) (
    input  logic                         i_clk,
    input  logic [earm_pkg::Q_BITS-1:0]  i_x,
    input  logic [earm_pkg::Q_BITS:0]    i_x2,
    input  logic [earm_pkg::Q_BITS-1:0]  i_t,
    output logic [earm_pkg::Q_BITS-1:0]  o_x,
    output logic [earm_pkg::Q_BITS:0]    o_x2,
    output logic [earm_pkg::Q_BITS-1:0]  o_t
);
    import earm_pkg::*;

    localparam logic [31:0] DIV32 = 32'(DIV);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

    logic [63:0]       w_pa;
    logic [31:0]       w_q0;
    logic [31:0]       w_rem;
    logic [31:0]       w_q;
    logic [31:0]       n_t;

    logic [31:0]       r_ya;
    logic [Q_BITS-1:0] r_xa;
    logic [Q_BITS:0]   r_x2a;
    logic [63:0]       r_pb;
    logic [31:0]       r_yb;
    logic [Q_BITS-1:0] r_xb;
    logic [Q_BITS:0]   r_x2b;
    logic [Q_BITS-1:0] r_t;
    logic [Q_BITS-1:0] r_xc;
    logic [Q_BITS:0]   r_x2c;

    assign w_pa  = 64'(i_x2) * 64'(i_t);
    assign w_q0  = r_pb[63:32];
    assign w_rem = r_yb - w_q0 * DIV32;
    assign w_q   = w_q0 + 32'(w_rem >= DIV32);
    assign n_t   = 32'(ONE_Q30) - w_q;

    always_ff @(posedge i_clk) begin
        r_ya  <= w_pa[61:30];
        r_xa  <= i_x;
        r_x2a <= i_x2;
        r_pb  <= 64'(r_ya) * 64'(RECIP);
        r_yb  <= r_ya;
        r_xb  <= r_xa;
        r_x2b <= r_x2a;
        r_t   <= n_t[Q_BITS-1:0];
        r_xc  <= r_xb;
        r_x2c <= r_x2b;
    end

    assign o_x  = r_xc;
    assign o_x2 = r_x2c;
    assign o_t  = r_t;

endmodule

[rtl/earm_sin_quarter.sv]
// ---------------------------------------------------------------------------
// earm_sin_quarter
// Pipelined sine of an angle within the first quarter turn, Q1.30 result.
// ---------------------------------------------------------------------------
module earm_sin_quarter #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic [ANGLE_BITS-2:0]        i_u,
    output logic [earm_pkg::Q_BITS-1:0]  o_s
);
    import earm_pkg::*;

    localparam int unsigned SH     = ANGLE_BITS - 2;
    localparam int unsigned U_BITS = SH + 1;
    localparam int unsigned P_BITS = U_BITS + Q_BITS;
    localparam logic [P_BITS-1:0] X_RND = P_BITS'(1) << (SH - 1);

    logic [P_BITS-1:0] w_xr;
    logic [31:0]       w_s;
    logic [Q_BITS-1:0] w_x  [POLY_TERMS+1];
    logic [Q_BITS:0]   w_x2 [POLY_TERMS+1];
    logic [Q_BITS-1:0] w_t  [POLY_TERMS+1];

    logic [P_BITS-1:0]   r_prod;
    logic [Q_BITS-1:0]   r_x;
    logic [2*Q_BITS-1:0] r_x2f;
    logic [Q_BITS-1:0]   r_x3;
    logic [2*Q_BITS-1:0] r_sf;
    logic [Q_BITS-1:0]   r_s;

    assign w_xr = r_prod + X_RND;

    always_ff @(posedge i_clk) begin
        r_prod <= P_BITS'(i_u) * P_BITS'(HALF_PI_Q30);
        r_x    <= Q_BITS'(w_xr >> SH);
        r_x2f  <= {31'd0, r_x} * {31'd0, r_x};
        r_x3   <= r_x;
    end

    assign w_x[0]  = r_x3;
    assign w_x2[0] = r_x2f[61:30];
    assign w_t[0]  = ONE_Q30;

    for (genvar g = 0; g < POLY_TERMS; g++) begin : g_term
        localparam int unsigned K = 2 * POLY_TERMS + 1 - 2 * g;

        earm_poly_term #(
            .DIV (K * (K - 1))
        ) u_term (
            .i_clk (i_clk),
            .i_x   (w_x[g]),
            .i_x2  (w_x2[g]),
            .i_t   (w_t[g]),
            .o_x   (w_x[g+1]),
            .o_x2  (w_x2[g+1]),
            .o_t   (w_t[g+1])
        );
    end

    assign w_s = r_sf[61:30];

    always_ff @(posedge i_clk) begin
        r_sf <= {31'd0, w_x[POLY_TERMS]} * {31'd0, w_t[POLY_TERMS]};
        r_s  <= (w_s > 32'(ONE_Q30)) ? ONE_Q30 : w_s[Q_BITS-1:0];
    end

    assign o_s = r_s;

endmodule

[rtl/earm_sincos.sv]
// ---------------------------------------------------------------------------
// earm_sincos
// Sine and cosine of a binary angle by quadrant folding onto two pipelined
// quarter-turn sine units. Results are a sign bit and a Q1.30 magnitude.
// ---------------------------------------------------------------------------
module earm_sincos #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [ANGLE_BITS-1:0]  i_angle,
    output earm_pkg::t_sincos      o_sc
);
    import earm_pkg::*;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quadrant;

    localparam int unsigned SH     = ANGLE_BITS - 2;
    localparam int unsigned U_BITS = SH + 1;
    localparam logic [U_BITS-1:0] QUARTER = U_BITS'(1) << SH;

    logic [Q_BITS-1:0] w_p;
    logic [Q_BITS-1:0] w_m;

    t_quadrant         r_quad_a;
    logic [U_BITS-1:0] r_up;
    logic [U_BITS-1:0] r_um;
    t_quadrant         r_quad [SQ_LAT];
    t_sincos           r_sc;

    always_ff @(posedge i_clk) begin
        r_quad_a <= t_quadrant'(i_angle[ANGLE_BITS-1 -: 2]);
        r_up     <= {1'b0, i_angle[SH-1:0]};
        r_um     <= QUARTER - {1'b0, i_angle[SH-1:0]};
        r_quad[0] <= r_quad_a;
        for (int i = 1; i < SQ_LAT; i++) begin
            r_quad[i] <= r_quad[i-1];
        end
    end

    earm_sin_quarter #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sin_p (
        .i_clk (i_clk),
        .i_u   (r_up),
        .o_s   (w_p)
    );

    earm_sin_quarter #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sin_m (
        .i_clk (i_clk),
        .i_u   (r_um),
        .o_s   (w_m)
    );

    always_ff @(posedge i_clk) begin
        unique case (r_quad[SQ_LAT-1])
            QUAD_0: begin
                r_sc <= '{s_neg: 1'b0, s_mag: w_p, c_neg: 1'b0, c_mag: w_m};
            end
            QUAD_1: begin
                r_sc <= '{s_neg: 1'b0, s_mag: w_m, c_neg: 1'b1, c_mag: w_p};
            end
            QUAD_2: begin
                r_sc <= '{s_neg: 1'b1, s_mag: w_p, c_neg: 1'b1, c_mag: w_m};
            end
            QUAD_3: begin
                r_sc <= '{s_neg: 1'b1, s_mag: w_m, c_neg: 1'b0, c_mag: w_p};
            end
        endcase
    end

    assign o_sc = r_sc;

endmodule

[rtl/earm_matrix.sv]
// ---------------------------------------------------------------------------
// earm_matrix
// Five-stage product and sum pipeline that forms the nine z-x-z matrix
// entries from three sine/cosine pairs and rounds them to the output format.
// ---------------------------------------------------------------------------
module earm_matrix #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  earm_pkg::t_sincos  i_a,
    input  earm_pkg::t_sincos  i_b,
    input  earm_pkg::t_sincos  i_c,
    output logic               o_valid,
    output earm_pkg::t_matrix  o_m
);
    import earm_pkg::*;

    localparam int unsigned NP = 10;
    localparam int unsigned NS = 8;
    localparam int unsigned NT = 4;

    localparam int unsigned P_CACC = 0;
    localparam int unsigned P_SACC = 1;
    localparam int unsigned P_CASC = 2;
    localparam int unsigned P_SASC = 3;
    localparam int unsigned P_SBSC = 4;
    localparam int unsigned P_SBCC = 5;
    localparam int unsigned P_SASB = 6;
    localparam int unsigned P_CASB = 7;
    localparam int unsigned P_SACB = 8;
    localparam int unsigned P_CACB = 9;

    localparam int unsigned T_SACB_SC = 0;
    localparam int unsigned T_SACB_CC = 1;
    localparam int unsigned T_CACB_SC = 2;
    localparam int unsigned T_CACB_CC = 3;

    localparam int          SHO     = 30 - int'(FRAC_BITS);
    localparam logic [33:0] OUT_RND = (SHO > 0) ? (34'd1 << (SHO - 1)) : 34'd0;
    localparam logic [33:0] OUT_LIM = 34'd1 << FRAC_BITS;

    function automatic logic [61:0] mul31(logic [Q_BITS-1:0] a, logic [Q_BITS-1:0] b);
        return {31'd0, a} * {31'd0, b};
    endfunction

    function automatic logic [Q_BITS-1:0] qround(logic [61:0] p);
        logic [61:0] s;
        s = p + 62'(32'h2000_0000);
        return s[60:30];
    endfunction

    function automatic logic signed [32:0] sv(logic neg, logic [Q_BITS-1:0] mag);
        logic signed [32:0] v;
        v = signed'({2'b00, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(logic signed [32:0] v);
        logic        neg;
        logic [33:0] mag;
        logic [33:0] res;
        neg = v[32];
        mag = 34'(neg ? -v : v);
        mag = (mag + OUT_RND) >> SHO;
        if (mag > OUT_LIM) begin
            mag = OUT_LIM;
        end
        res = neg ? (34'd0 - mag) : mag;
        return res[OUT_BITS-1:0];
    endfunction

    logic [Q_BITS-1:0] w_t [NT];

    logic [MX_LAT-1:0] r_v;

    logic [61:0]       r1_prod [NP];
    logic              r1_neg  [NP];
    logic              r1_sc_neg, r1_cc_neg, r1_cb_neg;
    logic [Q_BITS-1:0] r1_sc_mag, r1_cc_mag, r1_cb_mag;

    logic [Q_BITS-1:0] r2_mag [NP];
    logic              r2_neg [NP];
    logic              r2_sc_neg, r2_cc_neg, r2_cb_neg;
    logic [Q_BITS-1:0] r2_sc_mag, r2_cc_mag, r2_cb_mag;

    logic [61:0]       r3_trip [NT];
    logic              r3_tneg [NT];
    logic [Q_BITS-1:0] r3_mag  [NS];
    logic              r3_neg  [NS];
    logic              r3_cb_neg;
    logic [Q_BITS-1:0] r3_cb_mag;

    logic signed [32:0] r4_e [9];
    t_matrix            r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[MX_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod[P_CACC] <= mul31(i_a.c_mag, i_c.c_mag);
        r1_neg[P_CACC]  <= i_a.c_neg ^ i_c.c_neg;
        r1_prod[P_SACC] <= mul31(i_a.s_mag, i_c.c_mag);
        r1_neg[P_SACC]  <= i_a.s_neg ^ i_c.c_neg;
        r1_prod[P_CASC] <= mul31(i_a.c_mag, i_c.s_mag);
        r1_neg[P_CASC]  <= i_a.c_neg ^ i_c.s_neg;
        r1_prod[P_SASC] <= mul31(i_a.s_mag, i_c.s_mag);
        r1_neg[P_SASC]  <= i_a.s_neg ^ i_c.s_neg;
        r1_prod[P_SBSC] <= mul31(i_b.s_mag, i_c.s_mag);
        r1_neg[P_SBSC]  <= i_b.s_neg ^ i_c.s_neg;
        r1_prod[P_SBCC] <= mul31(i_b.s_mag, i_c.c_mag);
        r1_neg[P_SBCC]  <= i_b.s_neg ^ i_c.c_neg;
        r1_prod[P_SASB] <= mul31(i_a.s_mag, i_b.s_mag);
        r1_neg[P_SASB]  <= i_a.s_neg ^ i_b.s_neg;
        r1_prod[P_CASB] <= mul31(i_a.c_mag, i_b.s_mag);
        r1_neg[P_CASB]  <= i_a.c_neg ^ i_b.s_neg;
        r1_prod[P_SACB] <= mul31(i_a.s_mag, i_b.c_mag);
        r1_neg[P_SACB]  <= i_a.s_neg ^ i_b.c_neg;
        r1_prod[P_CACB] <= mul31(i_a.c_mag, i_b.c_mag);
        r1_neg[P_CACB]  <= i_a.c_neg ^ i_b.c_neg;
        r1_sc_neg <= i_c.s_neg;
        r1_sc_mag <= i_c.s_mag;
        r1_cc_neg <= i_c.c_neg;
        r1_cc_mag <= i_c.c_mag;
        r1_cb_neg <= i_b.c_neg;
        r1_cb_mag <= i_b.c_mag;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NP; i++) begin
            r2_mag[i] <= qround(r1_prod[i]);
            r2_neg[i] <= r1_neg[i];
        end
        r2_sc_neg <= r1_sc_neg;
        r2_sc_mag <= r1_sc_mag;
        r2_cc_neg <= r1_cc_neg;
        r2_cc_mag <= r1_cc_mag;
        r2_cb_neg <= r1_cb_neg;
        r2_cb_mag <= r1_cb_mag;
    end

    always_ff @(posedge i_clk) begin
        r3_trip[T_SACB_SC] <= mul31(r2_mag[P_SACB], r2_sc_mag);
        r3_tneg[T_SACB_SC] <= r2_neg[P_SACB] ^ r2_sc_neg;
        r3_trip[T_SACB_CC] <= mul31(r2_mag[P_SACB], r2_cc_mag);
        r3_tneg[T_SACB_CC] <= r2_neg[P_SACB] ^ r2_cc_neg;
        r3_trip[T_CACB_SC] <= mul31(r2_mag[P_CACB], r2_sc_mag);
        r3_tneg[T_CACB_SC] <= r2_neg[P_CACB] ^ r2_sc_neg;
        r3_trip[T_CACB_CC] <= mul31(r2_mag[P_CACB], r2_cc_mag);
        r3_tneg[T_CACB_CC] <= r2_neg[P_CACB] ^ r2_cc_neg;
        for (int i = 0; i < NS; i++) begin
            r3_mag[i] <= r2_mag[i];
            r3_neg[i] <= r2_neg[i];
        end
        r3_cb_neg <= r2_cb_neg;
        r3_cb_mag <= r2_cb_mag;
    end

    always_comb begin
        for (int j = 0; j < NT; j++) begin
            w_t[j] = qround(r3_trip[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_e[0] <= sv(r3_neg[P_CACC], r3_mag[P_CACC])
                 + sv(!r3_tneg[T_SACB_SC], w_t[T_SACB_SC]);
        r4_e[1] <= sv(r3_neg[P_SACC], r3_mag[P_SACC])
                 + sv(r3_tneg[T_CACB_SC], w_t[T_CACB_SC]);
        r4_e[2] <= sv(r3_neg[P_SBSC], r3_mag[P_SBSC]);
        r4_e[3] <= sv(!r3_neg[P_CASC], r3_mag[P_CASC])
                 + sv(!r3_tneg[T_SACB_CC], w_t[T_SACB_CC]);
        r4_e[4] <= sv(!r3_neg[P_SASC], r3_mag[P_SASC])
                 + sv(r3_tneg[T_CACB_CC], w_t[T_CACB_CC]);
        r4_e[5] <= sv(r3_neg[P_SBCC], r3_mag[P_SBCC]);
        r4_e[6] <= sv(r3_neg[P_SASB], r3_mag[P_SASB]);
        r4_e[7] <= sv(!r3_neg[P_CASB], r3_mag[P_CASB]);
        r4_e[8] <= sv(r3_cb_neg, r3_cb_mag);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_m[i] <= to_out(r4_e[i]);
        end
    end

    assign o_valid = r_v[MX_LAT-1];
    assign o_m     = r_m;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Euler z-x-z rotation matrix unit.
// ---------------------------------------------------------------------------
// Angle triples are queued by a stimulus process and presented by a clocked
// driver. Every accepted triple is run through a bit-exact fixed point model
// of the sine series, the products and the output rounding. The expected
// matrices are checked in order against each o_valid strobe. A directed set
// of quadrant edges and extremes comes first. Random triples follow in
// phases with sender idling of 0, 60, 0 and 15 percent, and each phase starts
// only after the pipeline has drained.
// ---------------------------------------------------------------------------
module tb;
    import earm_pkg::*;

    localparam int unsigned ANGLE_BITS = 16;
    localparam int unsigned FRAC_BITS  = 14;
    localparam int unsigned TAIL_CYCLES = 60;

    localparam longint unsigned ONE_FX     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_FX = 64'd1686629713;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] alpha;
        logic [ANGLE_BITS-1:0] beta;
        logic [ANGLE_BITS-1:0] gamma;
        logic [6:0]            idle_pct;
        logic                  drain;
    } t_angle_triple;

    typedef struct packed {
        logic signed [63:0] s;
        logic signed [63:0] c;
    } t_sin_cos;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ANGLE_BITS-1:0] i_alpha_angle = '0;
    logic [ANGLE_BITS-1:0] i_beta_angle = '0;
    logic [ANGLE_BITS-1:0] i_gamma_angle = '0;
    logic                  o_valid;
    logic signed [15:0]    o_m00, o_m01, o_m02;
    logic signed [15:0]    o_m10, o_m11, o_m12;
    logic signed [15:0]    o_m20, o_m21, o_m22;

    t_angle_triple pending_triples[$];
    t_matrix       expected_matrices[$];
    int            mismatches = 0;

    euler_angle_rotation_matrix_unit #(
        .ANGLE_BITS(ANGLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_alpha_angle(i_alpha_angle),
        .i_beta_angle (i_beta_angle),
        .i_gamma_angle(i_gamma_angle),
        .o_valid      (o_valid),
        .o_m00        (o_m00),
        .o_m01        (o_m01),
        .o_m02        (o_m02),
        .o_m10        (o_m10),
        .o_m11        (o_m11),
        .o_m12        (o_m12),
        .o_m20        (o_m20),
        .o_m21        (o_m21),
        .o_m22        (o_m22)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned quarter_sine(input longint unsigned u);
        longint unsigned x, x2, t, s, k;
        x = (u * HALF_PI_FX + (64'd1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        t = ONE_FX;
        for (k = 17; k >= 3; k = k - 2) begin
            t = ONE_FX - ((x2 * t) >> 30) / (k * (k - 1));
        end
        s = (x * t) >> 30;
        if (s > ONE_FX) begin
            s = ONE_FX;
        end
        return s;
    endfunction

    function automatic t_sin_cos angle_sin_cos(input logic [ANGLE_BITS-1:0] a);
        longint unsigned quarter, r;
        logic signed [63:0] p, m;
        t_sin_cos sc;
        quarter = 64'd1 << (ANGLE_BITS - 2);
        r = a[ANGLE_BITS-3:0];
        p = quarter_sine(r);
        m = quarter_sine(quarter - r);
        case (a[ANGLE_BITS-1 -: 2])
            2'd0: begin
                sc.s = p;
                sc.c = m;
            end
            2'd1: begin
                sc.s = m;
                sc.c = -p;
            end
            2'd2: begin
                sc.s = -p;
                sc.c = -m;
            end
            default: begin
                sc.s = -m;
                sc.c = p;
            end
        endcase
        return sc;
    endfunction

    function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic neg;
        longint unsigned ua, ub, p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = (ua * ub + (64'd1 << 29)) >> 30;
        return neg ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [15:0] round_entry(input logic signed [63:0] v);
        longint unsigned mag;
        logic [63:0] res;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (mag > (64'd1 << FRAC_BITS)) begin
            mag = 64'd1 << FRAC_BITS;
        end
        res = (v < 0) ? -mag : mag;
        return res[15:0];
    endfunction

    function automatic t_matrix rotation_matrix(input logic [ANGLE_BITS-1:0] alpha,
                                                input logic [ANGLE_BITS-1:0] beta,
                                                input logic [ANGLE_BITS-1:0] gamma);
        t_sin_cos a, b, g;
        t_matrix m;
        a = angle_sin_cos(alpha);
        b = angle_sin_cos(beta);
        g = angle_sin_cos(gamma);
        m[0] = round_entry(mul_q30(a.c, g.c) - mul_q30(mul_q30(a.s, b.c), g.s));
        m[1] = round_entry(mul_q30(a.s, g.c) + mul_q30(mul_q30(a.c, b.c), g.s));
        m[2] = round_entry(mul_q30(b.s, g.s));
        m[3] = round_entry(-mul_q30(a.c, g.s) - mul_q30(mul_q30(a.s, b.c), g.c));
        m[4] = round_entry(-mul_q30(a.s, g.s) + mul_q30(mul_q30(a.c, b.c), g.c));
        m[5] = round_entry(mul_q30(b.s, g.c));
        m[6] = round_entry(mul_q30(a.s, b.s));
        m[7] = round_entry(-mul_q30(a.c, b.s));
        m[8] = round_entry(b.c);
        return m;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        logic [ANGLE_BITS-1:0] base;
        if ($urandom_range(0, 3) == 0) begin
            base = {2'($urandom_range(0, 3)), {(ANGLE_BITS-2){1'b0}}};
            return base + ANGLE_BITS'($urandom_range(0, 8)) - ANGLE_BITS'(4);
        end
        return ANGLE_BITS'($urandom_range(0, (1 << ANGLE_BITS) - 1));
    endfunction

    task automatic add_triple(input logic [ANGLE_BITS-1:0] alpha,
                              input logic [ANGLE_BITS-1:0] beta,
                              input logic [ANGLE_BITS-1:0] gamma,
                              input int idle_pct, input logic drain);
        t_angle_triple tr;
        tr.alpha    = alpha;
        tr.beta     = beta;
        tr.gamma    = gamma;
        tr.idle_pct = 7'(idle_pct);
        tr.drain    = drain;
        pending_triples.push_back(tr);
    endtask

    always @(posedge i_clk) begin : drive_triples
        t_angle_triple nxt;
        logic          go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            go = start;
            if (start && !busy) begin
                expected_matrices.push_back(
                    rotation_matrix(i_alpha_angle, i_beta_angle, i_gamma_angle));
                go = 1'b0;
            end
            if (!go && pending_triples.size() > 0) begin
                nxt = pending_triples[0];
                if (!(nxt.drain && expected_matrices.size() > 0) &&
                    $urandom_range(0, 99) >= nxt.idle_pct) begin
                    void'(pending_triples.pop_front());
                    i_alpha_angle <= nxt.alpha;
                    i_beta_angle  <= nxt.beta;
                    i_gamma_angle <= nxt.gamma;
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    always @(posedge i_clk) begin : check_matrices
        t_matrix got, want;
        if (i_rst_n && o_valid) begin
            got = {o_m22, o_m21, o_m20, o_m12, o_m11, o_m10, o_m02, o_m01, o_m00};
            if (expected_matrices.size() == 0) begin
                $display("%0t: expected no matrix, actual m00 %0d",
                         $time, o_m00);
                mismatches++;
            end else begin
                want = expected_matrices.pop_front();
                for (int e = 0; e < 9; e++) begin
                    if (got[e] !== want[e]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time,
                                 e / 3, e % 3, $signed(want[e]), $signed(got[e]));
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int phase_idle[4];
        phase_idle = '{0, 60, 0, 15};

        add_triple(16'h0000, 16'h0000, 16'h0000, 0, 1'b0);
        add_triple(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        add_triple(16'h4000, 16'h0000, 16'h0000, 0, 1'b0);
        add_triple(16'h8000, 16'h0000, 16'h0000, 0, 1'b0);
        add_triple(16'hC000, 16'h0000, 16'h0000, 0, 1'b0);
        add_triple(16'h0000, 16'h4000, 16'h0000, 0, 1'b0);
        add_triple(16'h0000, 16'h8000, 16'h0000, 0, 1'b0);
        add_triple(16'h0000, 16'hC000, 16'h0000, 0, 1'b0);
        add_triple(16'h0000, 16'h0000, 16'h4000, 0, 1'b0);
        add_triple(16'h0000, 16'h0000, 16'h8000, 0, 1'b0);
        add_triple(16'h0000, 16'h0000, 16'hC000, 0, 1'b0);
        add_triple(16'h3FFF, 16'h4001, 16'hBFFF, 0, 1'b0);
        add_triple(16'h0001, 16'hFFFF, 16'h7FFF, 0, 1'b0);
        add_triple(16'h2000, 16'h2000, 16'h2000, 0, 1'b0);
        add_triple(16'hE000, 16'h6000, 16'hA000, 0, 1'b0);
        add_triple(16'h4000, 16'h4000, 16'h4000, 0, 1'b0);
        add_triple(16'h8000, 16'h8000, 16'h8000, 0, 1'b0);
        add_triple(16'hC000, 16'hC000, 16'hC000, 0, 1'b0);
        add_triple(16'h0001, 16'h0001, 16'h0001, 0, 1'b0);
        add_triple(16'hAAAA, 16'h5555, 16'hAAAA, 0, 1'b0);
        add_triple(16'h5555, 16'hAAAA, 16'h5555, 0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 500; n++) begin
                add_triple(pick_angle(), pick_angle(), pick_angle(),
                           phase_idle[ph], n == 0);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_triples.size() > 0 || start) begin
            @(posedge i_clk);
        end
        while (expected_matrices.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
